// ===== design/mtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared types and constants for the map tile pixel compositor.
// ----------------------------------------------------------------------------
package mtpc_pkg;

   localparam int TILE_SHIFT_DEF    = 8;
   localparam int MAX_ZOOM_DEF      = 20;
   localparam int MARKER_RADIUS_DEF = 9;
   localparam int RING_WIDTH_DEF    = 3;

   localparam logic [15:0] COLOUR_BG   = 16'h4A69;
   localparam logic [15:0] COLOUR_DOT  = 16'h1B1B;
   localparam logic [15:0] COLOUR_RING = 16'hFFFF;

   localparam logic [1:0] SRC_BG   = 2'd0;
   localparam logic [1:0] SRC_TILE = 2'd1;
   localparam logic [1:0] SRC_RING = 2'd2;
   localparam logic [1:0] SRC_DOT  = 2'd3;

   localparam logic [2:0] REG_VIEW_LEFT     = 3'd0;
   localparam logic [2:0] REG_VIEW_TOP      = 3'd1;
   localparam logic [2:0] REG_ZOOM_LEVEL    = 3'd2;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;
   localparam logic [2:0] REG_VIEW_VALID    = 3'd5;

   localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd800;
   localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;

   // load enables for the stages that the marker unit spans
   typedef struct packed {
      logic s2_en;
      logic s3_en;
   } stage_en_type;

endpackage

// ===== design/map_tile_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// map_tile_pixel_compositor
// Per-pixel source select for a slippy-map view: tile address, background
// or rider marker.
// ----------------------------------------------------------------------------
// One screen pixel per transfer, one result per pixel, in order. The path is
// four register stages (world add and center offset; tile split and
// squares; range checks and distance compare; output register), and a new
// pixel is taken every cycle while the result side keeps up. Each stage fills
// independently, so bubbles close up under output stall. Configuration
// writes take effect at once and belong only between pixels.
module map_tile_pixel_compositor #(
   parameter int TILE_SHIFT    = mtpc_pkg::TILE_SHIFT_DEF,
   parameter int MAX_ZOOM      = mtpc_pkg::MAX_ZOOM_DEF,
   parameter int MARKER_RADIUS = mtpc_pkg::MARKER_RADIUS_DEF,
   parameter int RING_WIDTH    = mtpc_pkg::RING_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [28:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [10:0] req_pix_x,
   input  logic [10:0] req_pix_y,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_source,
   output logic [15:0] rsp_colour,
   output logic [19:0] rsp_tile_col,
   output logic [19:0] rsp_tile_row,
   output logic [7:0]  rsp_tile_off_x,
   output logic [7:0]  rsp_tile_off_y
);

   localparam int OMASK = (1 << TILE_SHIFT) - 1;

   // configuration
   logic signed [28:0] view_left_ff;
   logic signed [28:0] view_top_ff;
   logic [4:0]         zoom_level_ff;
   logic [10:0]        screen_width_ff;
   logic [10:0]        screen_height_ff;
   logic               view_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_left_ff     <= '0;
         view_top_ff      <= '0;
         zoom_level_ff    <= '0;
         screen_width_ff  <= mtpc_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= mtpc_pkg::SCREEN_HEIGHT_RST;
         view_valid_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            mtpc_pkg::REG_VIEW_LEFT:     view_left_ff     <= csr_wdata;
            mtpc_pkg::REG_VIEW_TOP:      view_top_ff      <= csr_wdata;
            mtpc_pkg::REG_ZOOM_LEVEL:    zoom_level_ff    <= csr_wdata[4:0];
            mtpc_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[10:0];
            mtpc_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[10:0];
            mtpc_pkg::REG_VIEW_VALID:    view_valid_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic out_valid_ff;
   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy_out;
   mtpc_pkg::stage_en_type stage_en;

   always_comb begin
      rdy_out        = !out_valid_ff || rsp_ready;
      rdy3           = !s3_valid_ff || rdy_out;
      rdy2           = !s2_valid_ff || rdy3;
      rdy1           = !s1_valid_ff || rdy2;
      stage_en.s2_en = rdy2;
      stage_en.s3_en = rdy3;
   end

   assign req_ready = rdy1;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1)    s1_valid_ff  <= req_valid;
         if (rdy2)    s2_valid_ff  <= s1_valid_ff;
         if (rdy3)    s3_valid_ff  <= s2_valid_ff;
         if (rdy_out) out_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: world coordinate, center offset, off-screen
   logic signed [29:0] s1_wx_in;
   logic signed [29:0] s1_wy_in;
   logic signed [11:0] s1_dx_in;
   logic signed [11:0] s1_dy_in;
   logic               s1_bg_in;
   logic signed [29:0] s1_wx_ff;
   logic signed [29:0] s1_wy_ff;
   logic signed [11:0] s1_dx_ff;
   logic signed [11:0] s1_dy_ff;
   logic               s1_bg_ff;

   always_comb begin
      s1_wx_in = $signed({view_left_ff[28], view_left_ff}) + $signed({19'd0, req_pix_x});
      s1_wy_in = $signed({view_top_ff[28], view_top_ff}) + $signed({19'd0, req_pix_y});
      s1_dx_in = $signed({1'b0, req_pix_x}) - $signed({2'b00, screen_width_ff[10:1]});
      s1_dy_in = $signed({1'b0, req_pix_y}) - $signed({2'b00, screen_height_ff[10:1]});
      s1_bg_in = !view_valid_ff || (req_pix_x >= screen_width_ff)
                 || (req_pix_y >= screen_height_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_wx_ff <= s1_wx_in;
         s1_wy_ff <= s1_wy_in;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_bg_ff <= s1_bg_in;
      end
   end

   // stage 2: tile split and zoom clamp
   logic signed [29:0] tx_full;
   logic signed [29:0] ty_full;
   logic [4:0]         s2_zoom_in;
   logic [19:0]        s2_offx_in;
   logic [19:0]        s2_offy_in;
   logic signed [29:0] s2_tx_ff;
   logic signed [29:0] s2_ty_ff;
   logic [4:0]         s2_zoom_ff;
   logic [7:0]         s2_offx_ff;
   logic [7:0]         s2_offy_ff;
   logic               s2_bg_ff;

   always_comb begin
      tx_full    = s1_wx_ff >>> TILE_SHIFT;
      ty_full    = s1_wy_ff >>> TILE_SHIFT;
      s2_zoom_in = (zoom_level_ff > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom_level_ff;
      s2_offx_in = 20'(s1_wx_ff[7:0] & 8'(OMASK));
      s2_offy_in = 20'(s1_wy_ff[7:0] & 8'(OMASK));
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_tx_ff   <= tx_full;
         s2_ty_ff   <= ty_full;
         s2_zoom_ff <= s2_zoom_in;
         s2_offx_ff <= s2_offx_in[7:0];
         s2_offy_ff <= s2_offy_in[7:0];
         s2_bg_ff   <= s1_bg_ff;
      end
   end

   // stage 3: row range and column wrap
   logic [31:0] span;
   logic [31:0] tx_ext;
   logic [31:0] ty_ext;
   logic        s3_oob_in;
   logic [31:0] s3_col_in;
   logic        s3_oob_ff;
   logic [19:0] s3_col_ff;
   logic [19:0] s3_row_ff;
   logic [7:0]  s3_offx_ff;
   logic [7:0]  s3_offy_ff;
   logic        s3_bg_ff;

   always_comb begin
      span      = 32'd1 << s2_zoom_ff;
      tx_ext    = 32'(s2_tx_ff);
      ty_ext    = 32'(s2_ty_ff);
      s3_oob_in = s2_ty_ff[29] || (ty_ext >= span);
      s3_col_in = tx_ext & (span - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_oob_ff  <= s3_oob_in;
         s3_col_ff  <= s3_col_in[19:0];
         s3_row_ff  <= ty_ext[19:0];
         s3_offx_ff <= s2_offx_ff;
         s3_offy_ff <= s2_offy_ff;
         s3_bg_ff   <= s2_bg_ff;
      end
   end

   logic marker_hit;
   logic marker_outer;

   mtpc_marker #(
      .MARKER_RADIUS (MARKER_RADIUS),
      .RING_WIDTH    (RING_WIDTH)
   ) u_marker (
      .clock    (clock),
      .stage_en (stage_en),
      .dx       (s1_dx_ff),
      .dy       (s1_dy_ff),
      .hit      (marker_hit),
      .ring     (marker_outer)
   );

   // output stage
   logic [1:0]  source_in;
   logic [15:0] colour_in;
   logic [19:0] col_in;
   logic [19:0] row_in;
   logic [7:0]  offx_in;
   logic [7:0]  offy_in;
   logic [1:0]  source_ff;
   logic [15:0] colour_ff;
   logic [19:0] col_ff;
   logic [19:0] row_ff;
   logic [7:0]  offx_ff;
   logic [7:0]  offy_ff;

   always_comb begin
      source_in = mtpc_pkg::SRC_BG;
      colour_in = mtpc_pkg::COLOUR_BG;
      col_in    = '0;
      row_in    = '0;
      offx_in   = '0;
      offy_in   = '0;
      priority if (s3_bg_ff) begin
         source_in = mtpc_pkg::SRC_BG;
      end else if (marker_hit && marker_outer) begin
         source_in = mtpc_pkg::SRC_RING;
         colour_in = mtpc_pkg::COLOUR_RING;
      end else if (marker_hit) begin
         source_in = mtpc_pkg::SRC_DOT;
         colour_in = mtpc_pkg::COLOUR_DOT;
      end else if (s3_oob_ff) begin
         source_in = mtpc_pkg::SRC_BG;
      end else begin
         source_in = mtpc_pkg::SRC_TILE;
         colour_in = '0;
         col_in    = s3_col_ff;
         row_in    = s3_row_ff;
         offx_in   = s3_offx_ff;
         offy_in   = s3_offy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         source_ff <= source_in;
         colour_ff <= colour_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         offx_ff   <= offx_in;
         offy_ff   <= offy_in;
      end
   end

   assign rsp_source     = source_ff;
   assign rsp_colour     = colour_ff;
   assign rsp_tile_col   = col_ff;
   assign rsp_tile_row   = row_ff;
   assign rsp_tile_off_x = offx_ff;
   assign rsp_tile_off_y = offy_ff;

endmodule

// ===== design/mtpc_marker.sv =====
// ----------------------------------------------------------------------------
// mtpc_marker
// Marker classifier: distance from screen center, squared, against the
// outer and inner radius. Two register stages, driven by the top's enables.
// ----------------------------------------------------------------------------
module mtpc_marker #(
   parameter int MARKER_RADIUS = mtpc_pkg::MARKER_RADIUS_DEF,
   parameter int RING_WIDTH    = mtpc_pkg::RING_WIDTH_DEF
) (
   input  logic                  clock,
   input  mtpc_pkg::stage_en_type stage_en,
   input  logic signed [11:0]    dx,
   input  logic signed [11:0]    dy,
   output logic                  hit,
   output logic                  ring
);

   localparam int RW    = $clog2(MARKER_RADIUS + 1);
   localparam int SQ_W  = 2 * RW;
   localparam int SUM_W = SQ_W + 1;
   localparam int INNER = (MARKER_RADIUS > RING_WIDTH) ? (MARKER_RADIUS - RING_WIDTH) : 0;
   localparam int R2    = MARKER_RADIUS * MARKER_RADIUS;
   localparam int IN2   = INNER * INNER;

   logic [11:0]      mag_x;
   logic [11:0]      mag_y;
   logic             near_in;
   logic             near_ff;
   logic [SQ_W-1:0]  sqx_in;
   logic [SQ_W-1:0]  sqy_in;
   logic [SQ_W-1:0]  sqx_ff;
   logic [SQ_W-1:0]  sqy_ff;
   logic [SUM_W-1:0] d2;
   logic             hit_in;
   logic             ring_in;
   logic             hit_ff;
   logic             ring_ff;

   always_comb begin
      mag_x   = dx[11] ? 12'(-dx) : 12'(dx);
      mag_y   = dy[11] ? 12'(-dy) : 12'(dy);
      near_in = (mag_x <= 12'(MARKER_RADIUS)) && (mag_y <= 12'(MARKER_RADIUS));
      sqx_in  = SQ_W'(mag_x[RW-1:0]) * SQ_W'(mag_x[RW-1:0]);
      sqy_in  = SQ_W'(mag_y[RW-1:0]) * SQ_W'(mag_y[RW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2_en) begin
         near_ff <= near_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
      end
   end

   always_comb begin
      d2      = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      hit_in  = near_ff && (d2 <= SUM_W'(R2));
      ring_in = d2 > SUM_W'(IN2);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3_en) begin
         hit_ff  <= hit_in;
         ring_ff <= ring_in;
      end
   end

   assign hit  = hit_ff;
   assign ring = ring_ff;

endmodule

// ===== sim/map_tile_pixel_compositor_tb.sv =====
// ----------------------------------------------------------------------------
// map_tile_pixel_compositor_tb
// Checks the per-pixel source select of the map tile pixel compositor. Every
// pixel transfer is predicted in the bench from a shadow of the view
// registers and compared field by field with the result, in order. Directed
// pixels cover tile wrap, rows above and below the world, the marker ring and
// dot, off-screen pixels, an invalid view and the address extremes. Random
// views and pixels follow, with random idle on both sides and a long
// result-side hold that backs the pipe up.
// ----------------------------------------------------------------------------
module map_tile_pixel_compositor_tb;

   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 3000;
   localparam int VIEW_PHASES  = 22;
   localparam int PHASE_PIXELS = 80;

   typedef struct packed {
      logic [1:0]  source;
      logic [15:0] colour;
      logic [19:0] tile_col;
      logic [19:0] tile_row;
      logic [7:0]  off_x;
      logic [7:0]  off_y;
   } pixel_verdict_type;

   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
   } screen_pos_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [28:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [10:0] req_pix_x;
   logic [10:0] req_pix_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_source;
   logic [15:0] rsp_colour;
   logic [19:0] rsp_tile_col;
   logic [19:0] rsp_tile_row;
   logic [7:0]  rsp_tile_off_x;
   logic [7:0]  rsp_tile_off_y;

   // shadow of the view registers
   logic signed [28:0] shadow_left;
   logic signed [28:0] shadow_top;
   logic [4:0]         shadow_zoom;
   logic [10:0]        shadow_width;
   logic [10:0]        shadow_height;
   logic               shadow_valid;

   pixel_verdict_type pending_pixels[$];
   int                mismatches;
   int                stall_cycles;
   bit                tx_gaps_on;
   bit                rx_gaps_on;
   bit                hold_request;

   map_tile_pixel_compositor DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pix_x      (req_pix_x),
      .req_pix_y      (req_pix_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_source     (rsp_source),
      .rsp_colour     (rsp_colour),
      .rsp_tile_col   (rsp_tile_col),
      .rsp_tile_row   (rsp_tile_row),
      .rsp_tile_off_x (rsp_tile_off_x),
      .rsp_tile_off_y (rsp_tile_off_y)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic pixel_verdict_type compose_pixel(logic [10:0] px, logic [10:0] py);
      pixel_verdict_type v;
      int                dx, dy, d2, inner, zc;
      longint            wx, wy, tx, ty, span, col;
      v        = '0;
      v.source = mtpc_pkg::SRC_BG;
      v.colour = mtpc_pkg::COLOUR_BG;
      if (!shadow_valid || px >= shadow_width || py >= shadow_height) return v;
      dx    = int'(px) - int'(shadow_width >> 1);
      dy    = int'(py) - int'(shadow_height >> 1);
      d2    = dx * dx + dy * dy;
      inner = mtpc_pkg::MARKER_RADIUS_DEF - mtpc_pkg::RING_WIDTH_DEF;
      if (inner < 0) inner = 0;
      if (d2 <= mtpc_pkg::MARKER_RADIUS_DEF * mtpc_pkg::MARKER_RADIUS_DEF) begin
         if (d2 > inner * inner) begin
            v.source = mtpc_pkg::SRC_RING;
            v.colour = mtpc_pkg::COLOUR_RING;
         end else begin
            v.source = mtpc_pkg::SRC_DOT;
            v.colour = mtpc_pkg::COLOUR_DOT;
         end
         return v;
      end
      zc   = (shadow_zoom > mtpc_pkg::MAX_ZOOM_DEF) ? mtpc_pkg::MAX_ZOOM_DEF
                                                    : int'(shadow_zoom);
      span = longint'(1) << zc;
      wx   = longint'(shadow_left) + longint'(px);
      wy   = longint'(shadow_top) + longint'(py);
      tx   = wx >>> mtpc_pkg::TILE_SHIFT_DEF;
      ty   = wy >>> mtpc_pkg::TILE_SHIFT_DEF;
      if (ty < 0 || ty >= span) return v;
      col        = tx & (span - 1);
      wx         = wx & ((longint'(1) << mtpc_pkg::TILE_SHIFT_DEF) - 1);
      wy         = wy & ((longint'(1) << mtpc_pkg::TILE_SHIFT_DEF) - 1);
      v.source   = mtpc_pkg::SRC_TILE;
      v.colour   = '0;
      v.tile_col = col[19:0];
      v.tile_row = ty[19:0];
      v.off_x    = wx[7:0];
      v.off_y    = wy[7:0];
      return v;
   endfunction

   // mostly zero, some short, a few long
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [10:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd2;
         3:       return 11'd2047;
         default: return 11'($urandom_range(1, 2047));
      endcase
   endfunction

   function automatic screen_pos_type choose_pixel();
      screen_pos_type p;
      int unsigned    r;
      int             cx, cy;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         cx  = int'(shadow_width >> 1) + int'($urandom_range(0, 24)) - 12;
         cy  = int'(shadow_height >> 1) + int'($urandom_range(0, 24)) - 12;
         p.x = cx[10:0];
         p.y = cy[10:0];
      end else if (r < 27) begin
         p.x = 11'($urandom_range(0, 2047));
         p.y = 11'($urandom_range(0, 2047));
      end else begin
         p.x = (shadow_width == 0) ? 11'd0 : 11'($urandom_range(0, shadow_width - 1));
         p.y = (shadow_height == 0) ? 11'd0 : 11'($urandom_range(0, shadow_height - 1));
      end
      return p;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [28:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         mtpc_pkg::REG_VIEW_LEFT:     shadow_left   = data;
         mtpc_pkg::REG_VIEW_TOP:      shadow_top    = data;
         mtpc_pkg::REG_ZOOM_LEVEL:    shadow_zoom   = data[4:0];
         mtpc_pkg::REG_SCREEN_WIDTH:  shadow_width  = data[10:0];
         mtpc_pkg::REG_SCREEN_HEIGHT: shadow_height = data[10:0];
         mtpc_pkg::REG_VIEW_VALID:    shadow_valid  = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [28:0] left, logic [28:0] top, logic [4:0] zoom,
                            logic [10:0] w, logic [10:0] h, logic valid);
      wait_idle();
      write_reg(mtpc_pkg::REG_VIEW_LEFT, left);
      write_reg(mtpc_pkg::REG_VIEW_TOP, top);
      write_reg(mtpc_pkg::REG_ZOOM_LEVEL, {24'd0, zoom});
      write_reg(mtpc_pkg::REG_SCREEN_WIDTH, {18'd0, w});
      write_reg(mtpc_pkg::REG_SCREEN_HEIGHT, {18'd0, h});
      write_reg(mtpc_pkg::REG_VIEW_VALID, {28'd0, valid});
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(logic [10:0] px, logic [10:0] py);
      int unsigned gap;
      gap = tx_gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pix_x <= px;
      req_pix_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(compose_pixel(px, py));
   endtask

   task automatic test_tile_addressing();
      // zoom 2: four tiles each way; view starts left of and above the world
      configure(-29'sd300, -29'sd100, 5'd2, 11'd800, 11'd480, 1'b1);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd0, 11'd150);
      send_pixel(11'd799, 11'd479);
      send_pixel(11'd410, 11'd240);
   endtask

   task automatic test_marker();
      send_pixel(11'd400, 11'd240);
      send_pixel(11'd406, 11'd240);
      send_pixel(11'd407, 11'd240);
      send_pixel(11'd409, 11'd240);
      send_pixel(11'd405, 11'd245);
      send_pixel(11'd406, 11'd247);
   endtask

   task automatic test_off_screen();
      send_pixel(11'd800, 11'd0);
      send_pixel(11'd0, 11'd480);
      send_pixel(11'd2047, 11'd2047);
   endtask

   task automatic test_below_world();
      configure(-29'sd300, 29'sd900, 5'd2, 11'd800, 11'd480, 1'b1);
      send_pixel(11'd0, 11'd200);
      send_pixel(11'd0, 11'd0);
   endtask

   task automatic test_invalid_view();
      configure(29'sd0, 29'sd0, 5'd2, 11'd800, 11'd480, 1'b0);
      send_pixel(11'd400, 11'd240);
      send_pixel(11'd10, 11'd10);
   endtask

   task automatic test_address_extremes();
      // zoom past the clamp, view at the far corner of the world
      configure(29'h0FFF_FFFF, 29'h0FFF_FFFF, 5'd31, 11'd800, 11'd480, 1'b1);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd1, 11'd0);
      send_pixel(11'd1, 11'd1);
      // most negative left edge, single tile world
      configure(29'h1000_0000, 29'sd0, 5'd0, 11'd800, 11'd480, 1'b1);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd0, 11'd255);
      send_pixel(11'd0, 11'd256);
   endtask

   task automatic randomize_view();
      int unsigned z, zc, w, h, world, r;
      int          left, top;
      z     = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 31) : $urandom_range(0, 20);
      zc    = (z > mtpc_pkg::MAX_ZOOM_DEF) ? mtpc_pkg::MAX_ZOOM_DEF : z;
      world = 1 << (zc + mtpc_pkg::TILE_SHIFT_DEF);
      w     = 32'(pick_size());
      h     = 32'(pick_size());
      r     = $urandom_range(0, 99);
      if (r < 35)      top = int'($urandom_range(0, world)) - int'(h / 2);
      else if (r < 60) top = int'($urandom_range(0, 2 * h)) - int'(h);
      else if (r < 85) top = int'(world) - int'($urandom_range(0, 2 * h));
      else             top = int'($urandom);
      if ($urandom_range(0, 9) < 7) left = int'($urandom_range(0, world + 4096)) - 2048;
      else                          left = int'($urandom);
      configure(left[28:0], top[28:0], z[4:0], w[10:0], h[10:0],
                $urandom_range(0, 9) != 0);
   endtask

   task automatic test_output_backpressure();
      screen_pos_type p;
      configure(29'sd0, 29'sd0, 5'd3, 11'd64, 11'd48, 1'b1);
      tx_gaps_on   = 1'b0;
      rx_gaps_on   = 1'b0;
      hold_request = 1'b1;
      repeat (60) begin
         p = choose_pixel();
         send_pixel(p.x, p.y);
      end
      // sender waits out every result before going on
      wait_idle();
   endtask

   task automatic test_random_views();
      screen_pos_type p;
      int unsigned    mode;
      repeat (VIEW_PHASES) begin
         randomize_view();
         mode       = $urandom_range(0, 3);
         tx_gaps_on = mode[0];
         rx_gaps_on = mode[1];
         repeat (PHASE_PIXELS) begin
            p = choose_pixel();
            send_pixel(p.x, p.y);
         end
      end
   endtask

   task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      pixel_verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: result transfer with no pixel outstanding", $time);
         end else begin
            want = pending_pixels.pop_front();
            check_field("source", 20'(want.source), 20'(rsp_source));
            check_field("colour", 20'(want.colour), 20'(rsp_colour));
            check_field("tile_col", want.tile_col, rsp_tile_col);
            check_field("tile_row", want.tile_row, rsp_tile_row);
            check_field("tile_off_x", 20'(want.off_x), 20'(rsp_tile_off_x));
            check_field("tile_off_y", 20'(want.off_y), 20'(rsp_tile_off_y));
         end
      end
   end

   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_gaps_on) hold_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[map_tile_pixel_compositor] ERROR");
      $finish;
   end

   initial begin
      mismatches    = 0;
      stall_cycles  = 0;
      hold_request  = 1'b0;
      tx_gaps_on    = 1'b1;
      rx_gaps_on    = 1'b1;
      shadow_left   = '0;
      shadow_top    = '0;
      shadow_zoom   = '0;
      shadow_width  = mtpc_pkg::SCREEN_WIDTH_RST;
      shadow_height = mtpc_pkg::SCREEN_HEIGHT_RST;
      shadow_valid  = 1'b0;
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_pix_x <= '0;
      req_pix_y <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_invalid_view();
      test_tile_addressing();
      test_marker();
      test_off_screen();
      test_below_world();
      test_address_extremes();
      test_output_backpressure();
      test_random_views();

      wait_idle();
      if (mismatches == 0)
         $display("[map_tile_pixel_compositor] OK");
      else
         $display("[map_tile_pixel_compositor] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/mtpc_pkg.sv
design/mtpc_marker.sv
design/map_tile_pixel_compositor.sv
sim/map_tile_pixel_compositor_tb.sv
